// ===== sv/jaoe_pkg.sv =====
// Package with the character codes and parser phase codes of the JSON array object extractor.
`default_nettype none

package jaoe_pkg;

  localparam logic [2:0] PhSeekKey     = 3'd0;
  localparam logic [2:0] PhSeekBracket = 3'd1;
  localparam logic [2:0] PhBetween     = 3'd2;
  localparam logic [2:0] PhObject      = 3'd3;
  localparam logic [2:0] PhDone        = 3'd4;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerC    = 8'h63;
  localparam logic [7:0] ChColon     = 8'h3a;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] ChLf        = 8'h0a;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChOpenBrace    = 8'h7b;
  localparam logic [7:0] ChCloseBrace   = 8'h7d;
  localparam logic [7:0] ChOpenBracket  = 8'h5b;
  localparam logic [7:0] ChCloseBracket = 8'h5d;

  localparam logic [1:0] KeyLastIdx = 2'd3;

  // Characters of the quoted key, quotes included.
  function automatic logic [7:0] key_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = ChQuote;
      2'd1:    c = ChLowerA;
      2'd2:    c = ChLowerC;
      default: c = ChQuote;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/json_array_object_extractor.sv =====
// Top level of the JSON array object extractor: byte parser with input and result registers.
`default_nettype none

// Takes one body byte per beat and sends out the bytes of each top-level object of the
// array under the key "ac", up to the length limit and always the closing byte. A beat enters
// the input register, is parsed by a small state update and, if it is sent, lands in the result
// register, so a byte passes both registers on its way out; one byte can be taken in every cycle;
// the result register is the only thing that holds the input back, and only while the output side
// stalls. The byte that closes an object carries tlast, and tuser on it marks an object that
// outgrew the length limit and must be dropped.
module json_array_object_extractor
  import jaoe_pkg::*;
#(
  parameter int OBJECT_BUFFER_BYTES = 2048,
  parameter int MAX_NESTING         = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tuser_i,   // [0] restart
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o,   // last_of_object
  output logic            m_axis_tuser_o    // [0] discard
);

  localparam int LenW   = $clog2(OBJECT_BUFFER_BYTES);
  localparam int DepthW = $clog2(MAX_NESTING + 1);
  localparam logic [LenW-1:0]   LenMax   = LenW'(OBJECT_BUFFER_BYTES - 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_NESTING);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_restart_q;
  logic              advance;

  logic [2:0]        phase_q, phase_d;
  logic [1:0]        key_cnt_q, key_cnt_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              in_str_q, in_str_d;
  logic              esc_q, esc_d;
  logic              ovf_q, ovf_d;
  logic [LenW-1:0]   len_q, len_d;

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic              out_disc_q;
  logic              emit;
  logic              emit_last;
  logic              emit_disc;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q    <= s_axis_tdata_i;
      in_restart_q <= s_axis_tuser_i;
    end
  end

  always_comb begin
    logic [2:0]        ph;
    logic [1:0]        kc;
    logic [DepthW-1:0] dp;
    logic              st;
    logic              es;
    logic              ov;
    logic [LenW-1:0]   ln;
    logic              keep;
    logic [7:0]        c;

    c  = in_byte_q;
    ph = phase_q;
    kc = key_cnt_q;
    dp = depth_q;
    st = in_str_q;
    es = esc_q;
    ov = ovf_q;
    ln = len_q;
    if (in_restart_q) begin
      ph = PhSeekKey;
      kc = '0;
      dp = '0;
      st = 1'b0;
      es = 1'b0;
      ov = 1'b0;
      ln = '0;
    end

    emit      = 1'b0;
    emit_last = 1'b0;
    emit_disc = 1'b0;
    keep      = 1'b0;

    unique case (ph)
      PhSeekKey: begin
        if (c == key_char(kc)) begin
          if (kc == KeyLastIdx) begin
            kc = '0;
            ph = PhSeekBracket;
          end else begin
            kc = kc + 2'd1;
          end
        end else begin
          kc = (c == ChQuote) ? 2'd1 : 2'd0;
        end
      end
      PhSeekBracket: begin
        if (c == ChOpenBracket) begin
          ph = PhBetween;
        end else if (c != ChColon && c != ChSpace && c != ChTab && c != ChCr
                     && c != ChLf) begin
          ph = PhSeekKey;
          kc = '0;
        end
      end
      PhBetween: begin
        if (c == ChOpenBrace) begin
          ph   = PhObject;
          dp   = DepthW'(1);
          ln   = LenW'(1);
          ov   = 1'b0;
          st   = 1'b0;
          es   = 1'b0;
          emit = 1'b1;
        end else if (c == ChCloseBracket) begin
          ph = PhDone;
        end
      end
      PhObject: begin
        keep = (ln < LenMax);
        if (keep) begin
          ln = ln + LenW'(1);
        end else begin
          ov = 1'b1;
        end
        emit = keep;
        if (st) begin
          if (es) begin
            es = 1'b0;
          end else if (c == ChBackslash) begin
            es = 1'b1;
          end else if (c == ChQuote) begin
            st = 1'b0;
          end
        end else if (c == ChQuote) begin
          st = 1'b1;
        end else if (c == ChOpenBrace || c == ChOpenBracket) begin
          if (dp < DepthMax) begin
            dp = dp + DepthW'(1);
          end
        end else if (c == ChCloseBrace || c == ChCloseBracket) begin
          if (dp != '0) begin
            dp = dp - DepthW'(1);
          end
          if (dp == '0) begin
            ph        = PhBetween;
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_disc = ov;
          end
        end
      end
      default: begin
      end
    endcase

    phase_d   = ph;
    key_cnt_d = kc;
    depth_d   = dp;
    in_str_d  = st;
    esc_d     = es;
    ovf_d     = ov;
    len_d     = ln;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSeekKey;
      key_cnt_q   <= '0;
      depth_q     <= '0;
      in_str_q    <= 1'b0;
      esc_q       <= 1'b0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && emit;
      if (in_valid_q) begin
        phase_q   <= phase_d;
        key_cnt_q <= key_cnt_d;
        depth_q   <= depth_d;
        in_str_q  <= in_str_d;
        esc_q     <= esc_d;
        ovf_q     <= ovf_d;
        len_q     <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      out_byte_q <= in_byte_q;
      out_last_q <= emit_last;
      out_disc_q <= emit_disc;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_disc_q;

`ifndef SYNTHESIS
  a_discard_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("discard flag set on a beat that does not close an object");

  a_depth_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhObject) |-> (depth_q == '0))
    else $error("nesting depth not zero outside an object");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("object length counter past its limit");

  a_no_emit_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && !in_restart_q && phase_q == PhDone) |=> !m_axis_tvalid_o)
    else $error("beat sent after the closing bracket of the array");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_json_array_object_extractor.sv =====
// Self-checking testbench for the JSON array object extractor, with its own byte parser model.
module tb_json_array_object_extractor;
  import jaoe_pkg::*;

  localparam int BufferBytes = 2048;
  localparam int NestLimit   = 255;
  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 550;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_object;
    logic       discard;
  } obj_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;
  logic       s_axis_tuser_i = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic       m_axis_tuser_o;

  obj_beat_t  pending_beats [$];
  obj_beat_t  oldest_beat;
  logic [7:0] body_bytes [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic       no_idle = 1'b0;

  logic [2:0] phase;
  int         key_count;
  int         nest_depth;
  logic       in_string;
  logic       escape_next;
  logic       overflowed;
  int         kept_length;

  json_array_object_extractor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: out_byte %h last_of_object %b discard %b",
               m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        mismatch_count++;
      end else begin
        oldest_beat = pending_beats.pop_front();
        if (m_axis_tdata_o !== oldest_beat.out_byte) begin
          $error("out_byte: expected %h, actual %h", oldest_beat.out_byte, m_axis_tdata_o);
          mismatch_count++;
        end
        if (m_axis_tlast_o !== oldest_beat.last_of_object) begin
          $error("last_of_object: expected %b, actual %b",
                 oldest_beat.last_of_object, m_axis_tlast_o);
          mismatch_count++;
        end
        if (m_axis_tuser_o !== oldest_beat.discard) begin
          $error("discard: expected %b, actual %b", oldest_beat.discard, m_axis_tuser_o);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void clear_parser();
    phase       = PhSeekKey;
    key_count   = 0;
    nest_depth  = 0;
    in_string   = 1'b0;
    escape_next = 1'b0;
    overflowed  = 1'b0;
    kept_length = 0;
  endfunction

  // Advances the parser model by one byte and queues any beat it should produce.
  function automatic void parse_byte(input logic [7:0] c, input logic restart);
    logic [7:0] want;
    logic       keep;
    if (restart) clear_parser();
    case (phase)
      PhSeekKey: begin
        case (key_count)
          1:       want = ChLowerA;
          2:       want = ChLowerC;
          default: want = ChQuote;
        endcase
        if (c == want) begin
          key_count++;
          if (key_count >= 4) begin
            key_count = 0;
            phase = PhSeekBracket;
          end
        end else begin
          key_count = (c == ChQuote) ? 1 : 0;
        end
      end
      PhSeekBracket: begin
        if (c == ChOpenBracket) begin
          phase = PhBetween;
        end else if (c != ChColon && c != ChSpace && c != ChTab && c != ChCr && c != ChLf) begin
          phase = PhSeekKey;
          key_count = 0;
        end
      end
      PhBetween: begin
        if (c == ChOpenBrace) begin
          phase       = PhObject;
          nest_depth  = 1;
          kept_length = 1;
          overflowed  = 1'b0;
          in_string   = 1'b0;
          escape_next = 1'b0;
          pending_beats.push_back('{c, 1'b0, 1'b0});
        end else if (c == ChCloseBracket) begin
          phase = PhDone;
        end
      end
      PhObject: begin
        keep = kept_length < BufferBytes - 1;
        if (keep) kept_length++;
        else overflowed = 1'b1;
        if (in_string) begin
          if (escape_next) escape_next = 1'b0;
          else if (c == ChBackslash) escape_next = 1'b1;
          else if (c == ChQuote) in_string = 1'b0;
        end else if (c == ChQuote) begin
          in_string = 1'b1;
        end else if (c == ChOpenBrace || c == ChOpenBracket) begin
          if (nest_depth < NestLimit) nest_depth++;
        end else if (c == ChCloseBrace || c == ChCloseBracket) begin
          if (nest_depth > 0) nest_depth--;
          if (nest_depth == 0) begin
            phase = PhBetween;
            pending_beats.push_back('{c, 1'b1, overflowed});
            return;
          end
        end
        if (keep) pending_beats.push_back('{c, 1'b0, 1'b0});
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while (!no_idle && $urandom_range(99) < 9) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    parse_byte(b, restart);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic restart_first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], restart_first && i == 0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
  endtask

  task automatic push_space();
    repeat ($urandom_range(2)) begin
      case ($urandom_range(3))
        0:       body_bytes.push_back(ChSpace);
        1:       body_bytes.push_back(ChTab);
        2:       body_bytes.push_back(ChCr);
        default: body_bytes.push_back(ChLf);
      endcase
    end
  endtask

  task automatic push_string();
    logic [7:0] b;
    body_bytes.push_back(ChQuote);
    repeat ($urandom_range(6)) begin
      if ($urandom_range(4) == 0) begin
        body_bytes.push_back(ChBackslash);
        body_bytes.push_back(8'($urandom_range(255)));
      end else begin
        b = 8'($urandom_range(255));
        if (b == ChQuote || b == ChBackslash) b = ChOpenBrace;
        body_bytes.push_back(b);
      end
    end
    body_bytes.push_back(ChQuote);
  endtask

  task automatic push_object();
    int open_count;
    open_count = 1;
    body_bytes.push_back(ChOpenBrace);
    repeat ($urandom_range(12)) begin
      case ($urandom_range(5))
        0: push_string();
        1: if (open_count < 5) begin
          body_bytes.push_back($urandom_range(1) ? ChOpenBrace : ChOpenBracket);
          open_count++;
        end
        2: if (open_count > 1) begin
          body_bytes.push_back($urandom_range(1) ? ChCloseBrace : ChCloseBracket);
          open_count--;
        end
        3: body_bytes.push_back(ChColon);
        4: push_text(",");
        default: body_bytes.push_back(8'h30 + 8'($urandom_range(9)));
      endcase
    end
    while (open_count > 0) begin
      body_bytes.push_back($urandom_range(1) ? ChCloseBrace : ChCloseBracket);
      open_count--;
    end
  endtask

  task automatic send_body(input logic restart_first);
    for (int i = 0; i < body_bytes.size(); i++) begin
      send_byte(body_bytes[i], (restart_first && i == 0) || $urandom_range(299) == 0);
    end
    body_bytes.delete();
  endtask

  task automatic test_key_search();
    send_text("\"a\"ac\"", 1'b1);
    send_byte(ChColon, 1'b0);
    send_byte(ChSpace, 1'b0);
    send_byte(ChTab, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
    send_text("[x{}]{}", 1'b0);
    send_text("\"ac\"\"ac\"[{}", 1'b1);
  endtask

  task automatic test_object_capture();
    send_text("\"ac\":[{\"k\":\"}\\\"{\",\"n\":[1,{}]},", 1'b1);
    send_text("{[}]{\"a\\\\\"}", 1'b0);
    send_byte(ChOpenBrace, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("}]{}", 1'b0);
  endtask

  // Objects just inside, just at and well past the length limit.
  task automatic test_length_limit();
    int fill [3];
    fill = '{BufferBytes - 3, BufferBytes - 2, BufferBytes + 250};
    send_text("\"ac\":[", 1'b1);
    foreach (fill[k]) begin
      send_byte(ChOpenBrace, 1'b0);
      repeat (fill[k]) send_byte(ChLowerA + 8'($urandom_range(25)), 1'b0);
      send_text("},", 1'b0);
    end
    send_text("{}]", 1'b0);
  endtask

  task automatic test_depth_limit();
    send_text("\"ac\":[{", 1'b1);
    repeat (NestLimit + 45) send_byte($urandom_range(1) ? ChOpenBrace : ChOpenBracket, 1'b0);
    repeat (NestLimit + 1) send_byte($urandom_range(1) ? ChCloseBrace : ChCloseBracket, 1'b0);
    send_text("]", 1'b0);
  endtask

  task automatic test_random_bodies();
    int body_count;
    int sent_count;
    int cut;
    body_count = 0;
    sent_count = 0;
    while (sent_count < RandomBytes) begin
      no_idle = (body_count >= 8 && body_count < 16);
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 20)) body_bytes.push_back(8'($urandom_range(255)));
          send_body($urandom_range(1));
        end
        1: begin
          push_text("\"ac\":");
          push_space();
          if ($urandom_range(1)) push_text("[");
          push_object();
          cut = $urandom_range(body_bytes.size());
          while (body_bytes.size() > cut) void'(body_bytes.pop_back());
          send_body(1'b1);
        end
        default: begin
          if ($urandom_range(1)) push_text("{\"now\":17.5,");
          if ($urandom_range(2) == 0) push_text("\"ab\":0,\"a");
          push_text("\"ac\"");
          push_space();
          push_text(":");
          push_space();
          push_text("[");
          repeat ($urandom_range(1, 4)) begin
            push_space();
            push_object();
            push_text(",");
          end
          push_text("]}");
          sent_count += body_bytes.size();
          body_count++;
          send_body($urandom_range(9) != 0);
        end
      endcase
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_parser();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_key_search();
    test_object_capture();
    test_length_limit();
    test_depth_limit();
    test_random_bodies();
    s_axis_tvalid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/jaoe_pkg.sv
sv/json_array_object_extractor.sv
tb/tb_json_array_object_extractor.sv
